/* src/piecewise_linear_interp_assert.svh */
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// same-cycle implication, off during reset
`define PLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pli_pkg.sv */
`default_nettype none

package pli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int BIT_W      = $clog2(DATA_WIDTH + 1);
  localparam int PC_W       = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_VALUE   = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SETUP  = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_EMIT   = 6'b100000
  } pli_state_t;

  typedef struct packed {
    logic             wr;
    logic             capture;
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             chk;
    logic             first;
    logic             div_init;
    logic             div_step;
    logic [BIT_W-1:0] bit_sel;
    logic             finish;
    logic             emit;
  } pli_cmd_t;

  typedef struct packed {
    logic hit;
  } pli_sts_t;

endpackage

`default_nettype wire

/* src/piecewise_linear_interp.sv */
// channel  dir  transfer when        payload
// in_*     in   start && !busy       func, point_index, depth, point_value
// out_*    out  out_valid (1 cycle)  interp_value, in_range
// cfg_*    in   cfg_we               cfg_index, cfg_data
//
// a load transfer writes the table slot and busy stays low
// a query keeps busy high through scan, setup, divide, finish and emit, with no divide
// when no segment holds the depth; the result strobes in the same cycle that busy falls
// one table read per cycle during the scan, then a 33-step shift-subtract divider
// rst_n is synchronous, active low; table contents are undefined until loaded
// out_valid lasts one cycle and the receiver cannot stall it
`default_nettype none

module piecewise_linear_interp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_func,
  input  wire logic [pli_pkg::IDX_W-1:0]             in_point_index,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] in_depth,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] in_point_value,
  output logic                                       out_valid,
  output logic signed [pli_pkg::DATA_WIDTH-1:0]      out_interp_value,
  output logic                                       out_in_range,
  input  wire logic                                  cfg_we,
  input  wire logic [pli_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [pli_pkg::DATA_WIDTH-1:0]        cfg_data
);

  logic [pli_pkg::PC_W-1:0]              point_count_r;
  logic                                  cap_enable_r;
  logic signed [pli_pkg::DATA_WIDTH-1:0] cap_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= pli_pkg::PC_W'(1);
      cap_enable_r  <= 1'b0;
      cap_value_r   <= {1'b0, {(pli_pkg::DATA_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        pli_pkg::REG_POINT_COUNT: point_count_r <= cfg_data[pli_pkg::PC_W-1:0];
        pli_pkg::REG_CAP_ENABLE:  cap_enable_r  <= cfg_data[0];
        pli_pkg::REG_CAP_VALUE:   cap_value_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pli_pkg::pli_cmd_t cmd;
  pli_pkg::pli_sts_t sts;

  pli_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_func     (in_func),
    .point_count (point_count_r),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  pli_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_point_index   (in_point_index),
    .in_depth         (in_depth),
    .in_point_value   (in_point_value),
    .cap_enable       (cap_enable_r),
    .cap_value        (cap_value_r),
    .out_valid        (out_valid),
    .out_interp_value (out_interp_value),
    .out_in_range     (out_in_range)
  );

endmodule

`default_nettype wire

/* src/pli_ctrl.sv */
`default_nettype none
`include "piecewise_linear_interp_assert.svh"

module pli_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    in_func,
  input  wire logic [pli_pkg::PC_W-1:0] point_count,
  input  wire pli_pkg::pli_sts_t       sts,
  output pli_pkg::pli_cmd_t            cmd,
  output logic                         busy
);

  pli_pkg::pli_state_t              state_r, state_nxt;
  logic [pli_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [pli_pkg::BIT_W-1:0]        bit_r, bit_nxt;
  logic [pli_pkg::CNT_W-1:0]        n_pts;

  // clamp point count to 1..MAX_POINTS
  always_comb begin
    if (point_count == '0) begin
      n_pts = pli_pkg::CNT_W'(1);
    end else if (32'(point_count) > pli_pkg::MAX_POINTS) begin
      n_pts = pli_pkg::CNT_W'(pli_pkg::MAX_POINTS);
    end else begin
      n_pts = pli_pkg::CNT_W'(point_count);
    end
  end

  assign busy = (state_r != pli_pkg::ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = cnt_r[pli_pkg::IDX_W-1:0];
    cmd.bit_sel = bit_r;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    bit_nxt     = bit_r;
    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        if (start) begin
          if (in_func) begin
            cmd.capture = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = pli_pkg::ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      pli_pkg::ST_SCAN: begin
        cmd.rd    = (cnt_r < n_pts);
        cmd.chk   = (cnt_r != '0);
        cmd.first = (cnt_r == pli_pkg::CNT_W'(1));
        cnt_nxt   = cnt_r + pli_pkg::CNT_W'(1);
        if (cnt_r == n_pts) begin
          state_nxt = pli_pkg::ST_SETUP;
        end
      end
      pli_pkg::ST_SETUP: begin
        cmd.div_init = 1'b1;
        bit_nxt      = pli_pkg::BIT_W'(pli_pkg::DATA_WIDTH);
        state_nxt    = sts.hit ? pli_pkg::ST_DIV : pli_pkg::ST_FINISH;
      end
      pli_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = pli_pkg::ST_FINISH;
        end else begin
          bit_nxt = bit_r - pli_pkg::BIT_W'(1);
        end
      end
      pli_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = pli_pkg::ST_EMIT;
      end
      pli_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = pli_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pli_pkg::ST_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

  `PLI_ASSERT_NEXT(a_query_starts_scan, start && !busy && in_func, state_r == pli_pkg::ST_SCAN && cnt_r == '0, "query transfer did not start scan")
  `PLI_ASSERT_IMPL(a_scan_bound, state_r == pli_pkg::ST_SCAN, cnt_r <= n_pts, "scan ran past point count")
  `PLI_ASSERT_NEXT(a_emit_to_idle, state_r == pli_pkg::ST_EMIT, state_r == pli_pkg::ST_IDLE, "controller did not return to idle")

endmodule

`default_nettype wire

/* src/pli_dp.sv */
`default_nettype none
`include "piecewise_linear_interp_assert.svh"

module pli_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire pli_pkg::pli_cmd_t                    cmd,
  output pli_pkg::pli_sts_t                         sts,
  input  wire logic [pli_pkg::IDX_W-1:0]            in_point_index,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] in_depth,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] in_point_value,
  input  wire logic                                 cap_enable,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] cap_value,
  output logic                                      out_valid,
  output logic signed [pli_pkg::DATA_WIDTH-1:0]     out_interp_value,
  output logic                                      out_in_range
);

  localparam int W = pli_pkg::DATA_WIDTH;

  // breakpoint tables
  logic signed [W-1:0] dmem [pli_pkg::MAX_POINTS];
  logic signed [W-1:0] vmem [pli_pkg::MAX_POINTS];
  logic signed [W-1:0] rd_z_r, rd_v_r;
  logic                slot_ok;

  assign slot_ok = (pli_pkg::CNT_W'(in_point_index) < pli_pkg::CNT_W'(pli_pkg::MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      dmem[in_point_index] <= in_depth;
      vmem[in_point_index] <= in_point_value;
    end
    if (cmd.rd) begin
      rd_z_r <= dmem[cmd.rd_addr];
      rd_v_r <= vmem[cmd.rd_addr];
    end
  end

  // segment search
  logic signed [W-1:0] qz_r, prev_z_r, prev_v_r, dflt_r;
  logic signed [W-1:0] seg_z0_r, seg_z1_r, seg_v0_r, seg_v1_r;
  logic                hit_r;
  logic                seg_match;

  assign seg_match = (rd_z_r > prev_z_r) && (qz_r >= prev_z_r) && (qz_r <= rd_z_r);
  assign sts.hit   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.capture) begin
      hit_r <= 1'b0;
    end else if (cmd.chk && !cmd.first && seg_match) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qz_r <= in_depth;
    end
    if (cmd.chk) begin
      prev_z_r <= rd_z_r;
      prev_v_r <= rd_v_r;
      if (cmd.first) begin
        dflt_r <= rd_v_r;
      end else if (seg_match) begin
        seg_z0_r <= prev_z_r;
        seg_z1_r <= rd_z_r;
        seg_v0_r <= prev_v_r;
        seg_v1_r <= rd_v_r;
      end
    end
  end

  // operand setup
  logic [W:0]   w_full, dz_full, dv_up, dv_dn;
  logic         neg;
  logic [W-1:0] w_r, dz_r, r_r;
  logic [W:0]   mag_r, q_r;
  logic         neg_r;

  assign w_full  = {seg_z1_r[W-1], seg_z1_r} - {seg_z0_r[W-1], seg_z0_r};
  assign dz_full = {qz_r[W-1], qz_r} - {seg_z0_r[W-1], seg_z0_r};
  assign dv_up   = {seg_v1_r[W-1], seg_v1_r} - {seg_v0_r[W-1], seg_v0_r};
  assign dv_dn   = {seg_v0_r[W-1], seg_v0_r} - {seg_v1_r[W-1], seg_v1_r};
  assign neg     = (seg_v1_r < seg_v0_r);

  // scaled quotient, one bit of the magnitude per step
  logic [W+1:0] r2;
  logic [W+2:0] t1, t2;
  logic [1:0]   qd;
  logic [W-1:0] r_step;

  assign r2 = {1'b0, r_r, 1'b0} + (mag_r[cmd.bit_sel] ? {2'b00, dz_r} : {(W+2){1'b0}});
  assign t1 = {1'b0, r2} - {3'b000, w_r};
  assign t2 = {1'b0, r2} - {2'b00, w_r, 1'b0};

  always_comb begin
    if (!t2[W+2]) begin
      qd     = 2'd2;
      r_step = t2[W-1:0];
    end else if (!t1[W+2]) begin
      qd     = 2'd1;
      r_step = t1[W-1:0];
    end else begin
      qd     = 2'd0;
      r_step = r2[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      w_r   <= w_full[W-1:0];
      dz_r  <= dz_full[W-1:0];
      mag_r <= neg ? dv_dn : dv_up;
      neg_r <= neg;
      r_r   <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      r_r <= r_step;
      q_r <= {q_r[W-1:0], 1'b0} + (W+1)'(qd);
    end
  end

  // result and cap
  logic [W+1:0]        v0x, qx, sum;
  logic signed [W-1:0] res_r, out_value_r;
  logic                out_range_r, out_valid_r;
  logic                over;

  assign v0x  = {{2{seg_v0_r[W-1]}}, seg_v0_r};
  assign qx   = {1'b0, q_r};
  assign sum  = neg_r ? (v0x - qx) : (v0x + qx);
  assign over = cap_enable && (res_r > cap_value);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= hit_r ? sum[W-1:0] : dflt_r;
    end
    if (cmd.emit) begin
      out_value_r <= over ? cap_value : res_r;
      out_range_r <= hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_in_range     = out_range_r;

  `PLI_ASSERT_NEXT(a_rem_below_div, cmd.div_step, r_r < w_r, "remainder not below segment width")
  `PLI_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe longer than one cycle")

endmodule

`default_nettype wire
